### design/assert_macros.svh
// assertion macros used by the checker file of the hex record loader
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HRL_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define HRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/hrl_pkg.sv
// shared widths, character codes, line layout and nibble decode for the hex record loader
// no dependencies; used by the channel interfaces, the top level and the checker
`default_nettype none

package hrl_pkg;

   // field widths
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned ADDR_W  = 21;
   localparam int unsigned DATA_W  = 8;
   localparam int unsigned LIMIT_W = 21;
   localparam int unsigned POS_W   = 10;

   // character codes
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_W-1:0] UPPER_A_BIAS = 8'h37;

   // line layout: position of each header digit
   localparam logic [POS_W-1:0] POS_COUNT_HI  = 10'd1;
   localparam logic [POS_W-1:0] POS_COUNT_LO  = 10'd2;
   localparam logic [POS_W-1:0] POS_ADDR_D3   = 10'd3;
   localparam logic [POS_W-1:0] POS_ADDR_D2   = 10'd4;
   localparam logic [POS_W-1:0] POS_ADDR_D1   = 10'd5;
   localparam logic [POS_W-1:0] POS_ADDR_D0   = 10'd6;
   localparam logic [POS_W-1:0] POS_KIND_HI   = 10'd7;
   localparam logic [POS_W-1:0] POS_KIND_LO   = 10'd8;
   localparam logic [POS_W-1:0] PAYLOAD_START = 10'd9;
   localparam logic [POS_W-1:0] POS_MAX       = 10'd1023;
   localparam logic [POS_W-1:0] SEGMENT_DIGITS = 10'd4;

   // record types
   localparam logic [7:0] KIND_DATA    = 8'h00;
   localparam logic [7:0] KIND_SEGMENT = 8'h02;

   // limit after reset and the largest address the format can reach
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd65536;
   localparam logic [ADDR_W-1:0]  ADDR_MAX    = 21'd1114095;

   // uppercase hex digit to value, anything else to zero
   function automatic logic [3:0] nibble_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] t;
      t = '0;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         t = c - CHAR_DIGIT_0;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         t = c - UPPER_A_BIAS;
      end
      return t[3:0];
   endfunction

endpackage

`default_nettype wire

### design/hrl_channels.sv
// valid/ready channel interfaces: character beats in, memory write beats out
// depends on hrl_pkg for field widths
`default_nettype none

interface hrl_char_if;
   logic                        valid;
   logic                        ready;
   logic [hrl_pkg::CHAR_W-1:0]  ascii_char;

   modport source (output valid, output ascii_char, input ready);
   modport sink   (input valid, input ascii_char, output ready);
endinterface

interface hrl_write_if;
   logic                        valid;
   logic                        ready;
   logic [hrl_pkg::ADDR_W-1:0]  write_address;
   logic [hrl_pkg::DATA_W-1:0]  write_data;
   logic                        in_range;

   modport source (output valid, output write_address, output write_data, output in_range,
                   input ready);
   modport sink   (input valid, input write_address, input write_data, input in_range,
                   output ready);
endinterface

`default_nettype wire

### design/hex_record_loader_top.sv
// hex record loader top level: parses hex text one character per beat into memory writes
// depends on hrl_pkg and the channel interfaces in hrl_channels.sv
`default_nettype none

// Takes one character per beat and issues one write beat per completed data byte of a
// type 0 record, the cycle after the character that completes it. The line parser state
// is updated at the accepting edge by a short decode, and a single result register holds
// the write; req.ready is high whenever that register is empty or being drained, so a
// steady stream runs at one character per cycle while the sink keeps up. Type 2 records
// load the segment base at their newline. memory_limit (csr_write_data, reset 65536) is
// compared against each write address; writes at or above it come out with in_range low.
module hex_record_loader_top (
   input  logic                          clock,
   input  logic                          reset,
   hrl_char_if.sink                      req,
   hrl_write_if.source                   rsp,
   input  logic                          csr_write_enable,
   input  logic [hrl_pkg::LIMIT_W-1:0]   csr_write_data
);

   // parser state
   logic [hrl_pkg::POS_W-1:0]   line_pos_ff, line_pos_in;
   logic [7:0]                  rec_len_ff, rec_len_in;
   logic [15:0]                 rec_addr_ff, rec_addr_in;
   logic [7:0]                  rec_kind_ff, rec_kind_in;
   logic [3:0]                  high_nib_ff, high_nib_in;
   logic [7:0]                  bytes_ff, bytes_in;
   logic [15:0]                 pend_seg_ff, pend_seg_in;
   logic [15:0]                 seg_base_ff, seg_base_in;
   logic [hrl_pkg::LIMIT_W-1:0] limit_ff;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [hrl_pkg::ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [hrl_pkg::DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                        rsp_range_ff, rsp_range_in;

   logic                        accept;
   logic                        emit;
   logic [3:0]                  digit;
   logic [hrl_pkg::POS_W-1:0]   offset;
   logic [15:0]                 addr_low;
   logic [hrl_pkg::ADDR_W-1:0]  full_addr;

   // handshake: take a beat whenever the result register is free or draining
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // decode and address arithmetic
   assign digit     = hrl_pkg::nibble_of(req.ascii_char);
   assign offset    = line_pos_ff - hrl_pkg::PAYLOAD_START;
   assign addr_low  = rec_addr_ff + {8'b0, bytes_ff};
   assign full_addr = {1'b0, seg_base_ff, 4'b0} + {5'b0, addr_low};

   // parser next state
   always_comb begin
      line_pos_in = line_pos_ff;
      rec_len_in  = rec_len_ff;
      rec_addr_in = rec_addr_ff;
      rec_kind_in = rec_kind_ff;
      high_nib_in = high_nib_ff;
      bytes_in    = bytes_ff;
      pend_seg_in = pend_seg_ff;
      seg_base_in = seg_base_ff;
      emit        = 1'b0;
      if (accept) begin
         if (req.ascii_char == hrl_pkg::NEWLINE_CHAR) begin
            if (rec_kind_ff == hrl_pkg::KIND_SEGMENT) begin
               seg_base_in = pend_seg_ff;
            end
            line_pos_in = '0;
            rec_len_in  = '0;
            rec_addr_in = '0;
            rec_kind_in = '0;
            high_nib_in = '0;
            bytes_in    = '0;
            pend_seg_in = '0;
         end else begin
            case (line_pos_ff)
               hrl_pkg::POS_COUNT_HI: rec_len_in[7:4]    = digit;
               hrl_pkg::POS_COUNT_LO: rec_len_in[3:0]    = digit;
               hrl_pkg::POS_ADDR_D3:  rec_addr_in[15:12] = digit;
               hrl_pkg::POS_ADDR_D2:  rec_addr_in[11:8]  = digit;
               hrl_pkg::POS_ADDR_D1:  rec_addr_in[7:4]   = digit;
               hrl_pkg::POS_ADDR_D0:  rec_addr_in[3:0]   = digit;
               hrl_pkg::POS_KIND_HI:  rec_kind_in[7:4]   = digit;
               hrl_pkg::POS_KIND_LO:  rec_kind_in[3:0]   = digit;
               default: begin
                  if (line_pos_ff >= hrl_pkg::PAYLOAD_START) begin
                     if (rec_kind_ff == hrl_pkg::KIND_DATA) begin
                        // first digit of a pair is held, second completes the byte
                        if (!offset[0]) begin
                           high_nib_in = digit;
                        end else if (bytes_ff < rec_len_ff) begin
                           emit     = 1'b1;
                           bytes_in = bytes_ff + 8'd1;
                        end
                     end else if (rec_kind_ff == hrl_pkg::KIND_SEGMENT &&
                                  offset < hrl_pkg::SEGMENT_DIGITS) begin
                        case (offset[1:0])
                           2'd0:    pend_seg_in[15:12] = digit;
                           2'd1:    pend_seg_in[11:8]  = digit;
                           2'd2:    pend_seg_in[7:4]   = digit;
                           default: pend_seg_in[3:0]   = digit;
                        endcase
                     end
                  end
               end
            endcase
            // position counter saturates on overlong lines
            if (line_pos_ff != hrl_pkg::POS_MAX) begin
               line_pos_in = line_pos_ff + 10'd1;
            end
         end
      end
   end

   // result register next state
   always_comb begin
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_range_in = rsp_range_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = full_addr;
         rsp_data_in  = {high_nib_ff, digit};
         rsp_range_in = full_addr < limit_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_pos_ff  <= '0;
         rec_len_ff   <= '0;
         rec_addr_ff  <= '0;
         rec_kind_ff  <= '0;
         high_nib_ff  <= '0;
         bytes_ff     <= '0;
         pend_seg_ff  <= '0;
         seg_base_ff  <= '0;
         limit_ff     <= hrl_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         line_pos_ff  <= line_pos_in;
         rec_len_ff   <= rec_len_in;
         rec_addr_ff  <= rec_addr_in;
         rec_kind_ff  <= rec_kind_in;
         high_nib_ff  <= high_nib_in;
         bytes_ff     <= bytes_in;
         pend_seg_ff  <= pend_seg_in;
         seg_base_ff  <= seg_base_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_addr_ff  <= rsp_addr_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_range_ff <= rsp_range_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.write_address = rsp_addr_ff;
   assign rsp.write_data    = rsp_data_ff;
   assign rsp.in_range      = rsp_range_ff;

endmodule

`default_nettype wire

### design/hrl_checker.sv
// port-level checker for the hex record loader, bound to the top level
// depends on hrl_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hrl_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [hrl_pkg::CHAR_W-1:0]    req_ascii_char,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [hrl_pkg::ADDR_W-1:0]    rsp_write_address,
   input  logic [hrl_pkg::DATA_W-1:0]    rsp_write_data,
   input  logic                          rsp_in_range
);

   // a stalled write beat holds its contents
   `HRL_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_write_address, rsp_write_data, rsp_in_range}), "stalled write beat changed")

   // an empty result register never blocks the character stream
   `HRL_ASSERT_IMPLIES(a_empty_ready, clock, reset, !rsp_valid, req_ready, "input stalled with empty output")

   // a newline never produces a write
   `HRL_ASSERT_NEXT(a_newline_quiet, clock, reset, req_valid && req_ready && req_ascii_char == hrl_pkg::NEWLINE_CHAR, !rsp_valid, "write after newline")

   // segment base plus record address stays within the format's reach
   `HRL_ASSERT_IMPLIES(a_addr_reach, clock, reset, rsp_valid, rsp_write_address <= hrl_pkg::ADDR_MAX, "write address beyond segment reach")

endmodule

bind hex_record_loader_top hrl_checker u_hrl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .req_ascii_char    (req.ascii_char),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_write_address (rsp.write_address),
   .rsp_write_data    (rsp.write_data),
   .rsp_in_range      (rsp.in_range)
);

`default_nettype wire

### test/tb_hex_record_loader_top.sv
`timescale 1ns / 100ps
// self-checking testbench for hex_record_loader_top: random hex text in, predicted writes out
// depends on hrl_pkg and the channel interfaces in hrl_channels.sv
module tb_hex_record_loader_top;

   // characters and record types used to build the text
   localparam logic [hrl_pkg::CHAR_W-1:0] CHAR_COLON   = 8'h3A;
   localparam logic [hrl_pkg::CHAR_W-1:0] CHAR_CR      = 8'h0D;
   localparam logic [hrl_pkg::CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [hrl_pkg::CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] KIND_EOF          = 8'h01;
   localparam logic [7:0] KIND_START_SEG    = 8'h03;
   localparam logic [7:0] KIND_EXT_LINEAR   = 8'h04;
   localparam logic [7:0] KIND_START_LINEAR = 8'h05;
   localparam int PHASE_COUNT  = 7;
   localparam int PHASE_CHARS  = 110;
   localparam int LONG_LINE    = 1030;
   localparam int PRINT_CAP    = 40;

   typedef struct packed {
      logic [hrl_pkg::ADDR_W-1:0] write_address;
      logic [hrl_pkg::DATA_W-1:0] write_data;
      logic                       in_range;
   } mem_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                        csr_write_enable;
   logic [hrl_pkg::LIMIT_W-1:0] csr_write_data;

   hrl_char_if  req_if ();
   hrl_write_if rsp_if ();

   hex_record_loader_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // text waiting to be sent and writes waiting to come out
   logic [hrl_pkg::CHAR_W-1:0] text_queue[$];
   logic [hrl_pkg::CHAR_W-1:0] line_buf[$];
   mem_write_type              pending_writes[$];
   mem_write_type              next_write;

   // loader state as predicted
   logic [hrl_pkg::POS_W-1:0]   line_pos;
   logic [7:0]                  rec_len;
   logic [15:0]                 rec_addr;
   logic [7:0]                  rec_kind;
   logic [3:0]                  hi_nib;
   logic [7:0]                  bytes_done;
   logic [15:0]                 seg_pending;
   logic [15:0]                 seg_base;
   logic [hrl_pkg::LIMIT_W-1:0] mem_limit;

   bit char_taken;
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;
   int send_gap;
   int recv_stall;
   int chars_queued;
   int chars_accepted;
   int writes_checked;
   int writes_dropped;
   int limit_writes;
   int mismatch_count;

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP) begin
         $display("mismatch @ %0t ns: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // uppercase hex digit value, anything else is zero
   function automatic logic [3:0] digit_value(input logic [hrl_pkg::CHAR_W-1:0] c);
      if (c >= hrl_pkg::CHAR_DIGIT_0 && c <= hrl_pkg::CHAR_DIGIT_9) return c[3:0];
      else if (c >= hrl_pkg::CHAR_UPPER_A && c <= hrl_pkg::CHAR_UPPER_F)
         return c[3:0] + 4'd9;
      else return 4'd0;
   endfunction

   task automatic clear_line();
      line_pos    = '0;
      rec_len     = '0;
      rec_addr    = '0;
      rec_kind    = '0;
      hi_nib      = '0;
      bytes_done  = '0;
      seg_pending = '0;
   endtask

   // advance the predicted parser by one character
   task automatic parse_char(input logic [hrl_pkg::CHAR_W-1:0] c);
      logic [3:0]                d;
      logic [hrl_pkg::POS_W-1:0] off;
      logic [15:0]               lo;
      mem_write_type             w;
      if (c == hrl_pkg::NEWLINE_CHAR) begin
         if (rec_kind == hrl_pkg::KIND_SEGMENT) seg_base = seg_pending;
         clear_line();
      end else begin
         d = digit_value(c);
         case (line_pos)
            hrl_pkg::POS_COUNT_HI: rec_len[7:4]    = d;
            hrl_pkg::POS_COUNT_LO: rec_len[3:0]    = d;
            hrl_pkg::POS_ADDR_D3:  rec_addr[15:12] = d;
            hrl_pkg::POS_ADDR_D2:  rec_addr[11:8]  = d;
            hrl_pkg::POS_ADDR_D1:  rec_addr[7:4]   = d;
            hrl_pkg::POS_ADDR_D0:  rec_addr[3:0]   = d;
            hrl_pkg::POS_KIND_HI:  rec_kind[7:4]   = d;
            hrl_pkg::POS_KIND_LO:  rec_kind[3:0]   = d;
            default: begin
               if (line_pos >= hrl_pkg::PAYLOAD_START) begin
                  off = line_pos - hrl_pkg::PAYLOAD_START;
                  if (rec_kind == hrl_pkg::KIND_DATA) begin
                     // second digit of a pair completes a byte, up to the count
                     if (!off[0]) begin
                        hi_nib = d;
                     end else if (bytes_done < rec_len) begin
                        lo = rec_addr + 16'(bytes_done);
                        w.write_address = {1'b0, seg_base, 4'h0} + {5'b0, lo};
                        w.write_data    = {hi_nib, d};
                        w.in_range      = (w.write_address < mem_limit);
                        pending_writes.push_back(w);
                        bytes_done++;
                     end
                  end else if (rec_kind == hrl_pkg::KIND_SEGMENT &&
                               off < hrl_pkg::SEGMENT_DIGITS) begin
                     seg_pending = seg_pending | (16'(d) << (12 - 4 * off));
                  end
               end
            end
         endcase
         if (line_pos != hrl_pkg::POS_MAX) line_pos++;
      end
   endtask

   // character driver, changes at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || char_taken) begin
         if (send_gap != 0) begin
            req_if.valid <= 1'b0;
            send_gap--;
         end else if (text_queue.size() != 0) begin
            req_if.valid      <= 1'b1;
            req_if.ascii_char <= text_queue.pop_front();
            if (send_idle) send_gap = pick_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // write sink back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (recv_stall != 0) begin
         rsp_if.ready <= 1'b0;
         recv_stall--;
      end else begin
         rsp_if.ready <= 1'b1;
         if (recv_idle) recv_stall = pick_gap();
      end
   end

   // monitor: predict on each character beat, check each write beat
   always @(posedge clock) begin
      if (reset) begin
         char_taken <= 1'b0;
         clear_line();
         seg_base  = '0;
         mem_limit = hrl_pkg::LIMIT_RESET;
      end else begin
         char_taken <= req_if.valid && req_if.ready;
         if (csr_write_enable) mem_limit = csr_write_data;
         if (req_if.valid && req_if.ready) begin
            parse_char(req_if.ascii_char);
            chars_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_writes.size() == 0) begin
               report_mismatch($sformatf("unexpected write beat addr %h data %h",
                                         rsp_if.write_address, rsp_if.write_data));
            end else begin
               next_write = pending_writes.pop_front();
               if (rsp_if.write_address !== next_write.write_address)
                  report_mismatch($sformatf("write_address %h, expected %h",
                                            rsp_if.write_address, next_write.write_address));
               if (rsp_if.write_data !== next_write.write_data)
                  report_mismatch($sformatf("write_data %h, expected %h at %h",
                                            rsp_if.write_data, next_write.write_data,
                                            next_write.write_address));
               if (rsp_if.in_range !== next_write.in_range)
                  report_mismatch($sformatf("in_range %b, expected %b at %h limit %0d",
                                            rsp_if.in_range, next_write.in_range,
                                            next_write.write_address, mem_limit));
               writes_checked++;
               if (!next_write.in_range) writes_dropped++;
            end
         end
      end
   end

   // text building
   task automatic push_text(input logic [hrl_pkg::CHAR_W-1:0] c);
      text_queue.push_back(c);
      chars_queued++;
   endtask

   task automatic push_string(input string s);
      for (int i = 0; i < s.len(); i++) push_text(8'(s[i]));
   endtask

   function automatic logic [hrl_pkg::CHAR_W-1:0] hex_digit(input logic [3:0] n);
      return (n < 4'd10) ? 8'(hrl_pkg::CHAR_DIGIT_0 + n)
                         : 8'(hrl_pkg::CHAR_UPPER_A + n - 4'd10);
   endfunction

   function automatic logic [hrl_pkg::CHAR_W-1:0] any_but_newline();
      logic [hrl_pkg::CHAR_W-1:0] c;
      c = 8'($urandom_range(0, 254));
      if (c >= hrl_pkg::NEWLINE_CHAR) c++;
      return c;
   endfunction

   task automatic line_hex(input logic [7:0] b);
      line_buf.push_back(hex_digit(b[7:4]));
      line_buf.push_back(hex_digit(b[3:0]));
   endtask

   // header plus a number of random payload bytes
   task automatic build_record(input logic [7:0] kind, input logic [7:0] count,
                               input logic [15:0] addr, input int payload);
      line_buf.delete();
      line_buf.push_back(CHAR_COLON);
      line_hex(count);
      line_hex(addr[15:8]);
      line_hex(addr[7:0]);
      line_hex(kind);
      repeat (payload) line_hex(8'($urandom_range(0, 255)));
   endtask

   task automatic send_line(input bit terminate);
      foreach (line_buf[i]) push_text(line_buf[i]);
      if (terminate) begin
         if ($urandom_range(0, 4) == 0) push_text(CHAR_CR);
         push_text(hrl_pkg::NEWLINE_CHAR);
      end
   endtask

   task automatic build_data_record(input int max_count);
      logic [7:0]  count;
      logic [15:0] addr;
      int          extra;
      count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(max_count, 48))
                                          : 8'($urandom_range(0, max_count));
      addr  = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                          : 16'($urandom_range(0, 16'hFFFF));
      extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
      build_record(hrl_pkg::KIND_DATA, count, addr, int'(count) + 1 + extra);
   endtask

   // one random line: mostly well-formed records, some noise and damage
   task automatic add_random_line();
      int          r;
      int          sel;
      int          cut;
      int          idx;
      logic [15:0] seg;
      logic [7:0]  kind;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         build_data_record(16);
      end else if (r < 70) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) seg = 16'h0000;
         else if (sel == 1) seg = 16'hFFFF;
         else if (sel < 6) seg = 16'($urandom_range(0, 16'h0FFF));
         else seg = 16'($urandom_range(0, 16'hFFFF));
         build_record(hrl_pkg::KIND_SEGMENT, 8'h02, 16'h0000, 0);
         line_hex(seg[15:8]);
         line_hex(seg[7:0]);
         line_hex(8'($urandom_range(0, 255)));
      end else if (r < 78) begin
         case ($urandom_range(0, 4))
            0: kind = KIND_EOF;
            1: kind = KIND_START_SEG;
            2: kind = KIND_EXT_LINEAR;
            3: kind = KIND_START_LINEAR;
            default: kind = 8'($urandom_range(0, 255));
         endcase
         build_record(kind, 8'($urandom_range(0, 8)), 16'($urandom_range(0, 16'hFFFF)),
                      $urandom_range(1, 9));
      end else if (r < 86) begin
         // raw noise, newlines included
         line_buf.delete();
         repeat ($urandom_range(0, 24)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         // damaged record: a few characters replaced
         build_data_record(12);
         repeat ($urandom_range(1, 3)) begin
            idx = $urandom_range(0, line_buf.size() - 1);
            line_buf[idx] = ($urandom_range(0, 1) == 0)
                            ? 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_F))
                            : any_but_newline();
         end
      end
      // short line now and then
      if (r < 86 && $urandom_range(0, 9) == 0) begin
         cut = $urandom_range(0, line_buf.size());
         while (line_buf.size() > cut) void'(line_buf.pop_back());
      end
      send_line(1'b1);
   endtask

   // wait until everything sent has been answered, then a few idle cycles
   task automatic wait_idle();
      while (text_queue.size() != 0 || req_if.valid || pending_writes.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [hrl_pkg::LIMIT_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      limit_writes++;
   endtask

   // stimulus sequence
   initial begin
      int                          ph;
      int                          target;
      logic [hrl_pkg::LIMIT_W-1:0] limit;
      req_if.valid      = 1'b0;
      req_if.ascii_char = '0;
      rsp_if.ready      = 1'b0;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wrap of the record address, data extremes, then the largest segment
      push_string(":02FFFF00FF00");
      push_text(hrl_pkg::NEWLINE_CHAR);
      push_string(":02000002FFFF");
      push_text(hrl_pkg::NEWLINE_CHAR);
      wait_idle();

      // random text under a range of memory limits and idling patterns
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         send_idle = 1'b1;
         recv_idle = 1'b1;
         case (ph)
            0: limit = 21'd1;
            1: limit = 21'd0;
            2: begin
               limit = 21'h1FFFFF;
               send_idle = 1'b0;
               recv_idle = 1'b0;
            end
            3: begin
               limit = 21'd1048576;
               send_idle = 1'b0;
            end
            4: begin
               limit = 21'($urandom_range(1, 1048576));
               recv_idle = 1'b0;
            end
            5: limit = hrl_pkg::LIMIT_RESET;
            default: limit = 21'($urandom_range(1, 1114096));
         endcase
         write_limit(limit);
         target = chars_queued + PHASE_CHARS;
         while (chars_queued < target) add_random_line();
         wait_idle();
      end

      // full 255-byte record across the address wrap, padded past the position cap
      send_idle = 1'b1;
      recv_idle = 1'b1;
      write_limit(hrl_pkg::ADDR_MAX);
      build_record(hrl_pkg::KIND_SEGMENT, 8'h02, 16'h0000, 0);
      line_hex(8'hFF);
      line_hex(8'hFF);
      send_line(1'b1);
      build_record(hrl_pkg::KIND_DATA, 8'hFF, 16'hFFF0, 256);
      while (line_buf.size() < LONG_LINE) line_buf.push_back(any_but_newline());
      send_line(1'b1);

      // last line with no newline still writes its bytes
      build_record(hrl_pkg::KIND_DATA, 8'h03, 16'($urandom_range(0, 16'hFFFF)), 3);
      send_line(1'b0);
      wait_idle();
      repeat (8) @(posedge clock);

      while (pending_writes.size() != 0) begin
         next_write = pending_writes.pop_front();
         report_mismatch($sformatf("write to %h never came out", next_write.write_address));
      end
      $display("run covered %0d characters and %0d write beats, %0d of them out of range",
               chars_accepted, writes_checked, writes_dropped);
      $display("memory limit written %0d times, extremes and a saturated long line included",
               limit_writes);
      if (mismatch_count == 0) begin
         $display("tb_hex_record_loader_top: PASS");
      end else begin
         $display("tb_hex_record_loader_top: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("tb_hex_record_loader_top: FAIL");
      $finish;
   end

endmodule
